// File: design/b2sp_pkg.sv
// Shared types, constants and mixing functions for the BLAKE2sp tree hash core.
// Used by b2sp_compress and blake2sp_tree_hash_core; depends on nothing else.
`default_nettype none
package b2sp_pkg;

  localparam logic [31:0] IV [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};

  localparam logic [31:0] PARAM_WORD0 = 32'h02080020;
  localparam logic [31:0] LEAF_WORD3  = 32'h20000000;
  localparam logic [31:0] ROOT_WORD3  = 32'h20010000;
  localparam logic [31:0] ALL_ONES    = 32'hFFFFFFFF;
  localparam int          LAST_ROUND  = 9;

  // Each row packs the sixteen message indices of one round, entry k in bits 4k+3:4k.
  localparam logic [63:0] SIGMA [10] = '{
    64'hFEDCBA9876543210, 64'h357B20C16DF984AE, 64'h491763EADF250C8B,
    64'h8F04A562EBCD1397, 64'hD386CB1EFA427509, 64'h91EF57D438B0A6C2,
    64'hB8293670A4DEF15C, 64'hA2684F05931CE7BD, 64'h5A417D2C803B9EF6,
    64'h0DC3E9BF5167482A};

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } g_t;

  typedef struct packed {
    logic        valid;
    logic [4:0]  idx;
    logic [31:0] data;
  } b2sp_load_t;

  typedef struct packed {
    logic        start;
    logic        f0;
    logic        f1;
    logic [63:0] count;
  } b2sp_cmd_t;

  function automatic g_t g_mix(input logic [31:0] a, input logic [31:0] b,
                               input logic [31:0] c, input logic [31:0] d,
                               input logic [31:0] x, input logic [31:0] y);
    logic [31:0] a1, b1, c1, d1, t;
    g_t r;
    a1 = a + b + x;
    t  = d ^ a1;
    d1 = {t[15:0], t[31:16]};
    c1 = c + d1;
    t  = b ^ c1;
    b1 = {t[11:0], t[31:12]};
    a1 = a1 + b1 + y;
    t  = d1 ^ a1;
    d1 = {t[7:0], t[31:8]};
    c1 = c1 + d1;
    t  = b1 ^ c1;
    b1 = {t[6:0], t[31:7]};
    r.a = a1;
    r.b = b1;
    r.c = c1;
    r.d = d1;
    return r;
  endfunction

  function automatic logic [31:0] init_word(input logic [2:0] leaf, input logic [2:0] w,
                                            input logic root);
    logic [31:0] r;
    case (w)
      3'd0:    r = IV[0] ^ PARAM_WORD0;
      3'd2:    r = IV[2] ^ {29'd0, leaf};
      3'd3:    r = IV[3] ^ (root ? ROOT_WORD3 : LEAF_WORD3);
      default: r = IV[w];
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/blake2sp_tree_hash_core.sv
// Top level of the BLAKE2sp tree hash core: block and chaining memories, sequencer, output.
// Depends on b2sp_pkg and b2sp_compress.
//
// Message words enter on the s_axis side, one little-endian 32-bit word per transfer; every
// word before the last must hold four bytes. A word is normally taken in S_IDLE and
// written to the block memory in S_PUT. A word that opens a new block for a leaf that
// already holds one first compresses the held block: 24 one-word reads from the block and
// chaining memories, a run of the compression unit and eight chaining words written
// back. The last word finalizes eight leaves and four root blocks through that one unit,
// then the eight digest words leave on the m_axis side, word index in tuser and tlast on
// the eighth, after which the core is back in its reset state. No clearing pass is needed.
`default_nettype none
module blake2sp_tree_hash_core #(
  parameter int COUNTER_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // data_word [31:0], byte_count [34:32], zero above
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // digest_word [31:0]
  output logic [2:0]  m_axis_tuser,   // word_index [2:0]
  output logic        m_axis_tlast
);
  import b2sp_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_GO, S_RUN, S_STORE, S_PUT, S_OUT} state_t;
  typedef enum logic [1:0] {SRC_BLK, SRC_CHAIN, SRC_ROOT} src_t;

  state_t state;
  logic [4:0]  lc;
  logic [2:0]  sc;
  logic        job_root, job_final;
  logic [2:0]  job_idx;
  logic [31:0] in_data;
  logic [2:0]  in_n;
  logic        in_last;
  logic [8:0]  pos;
  logic [7:0]  holds, fresh;
  logic [COUNTER_BITS-1:0] tot [8];
  logic [31:0] root_h [8];
  logic [2:0]  out_k;

  logic [31:0] blk_mem [128];
  logic [31:0] chain_mem [64];
  logic [31:0] blk_q, chain_q;
  logic [6:0]  blk_raddr;
  logic [5:0]  chain_raddr;

  logic        rd_valid, rd_keep, rd_fresh;
  logic [4:0]  rd_idx;
  src_t        rd_src, issue_src;
  logic [5:0]  rd_addr;
  logic [31:0] rd_rootw, rd_sel;
  logic        issue_keep;

  logic [2:0]  n_raw, n_eff;
  logic [31:0] data_m;
  logic [2:0]  cur_leaf, fidx;
  logic [3:0]  cur_off, loff;
  logic [8:0]  p1;
  logic [6:0]  flen, len;
  logic [COUNTER_BITS-1:0] tot_new;
  logic [8:0]  root_count;
  logic        accept, out_hs;

  b2sp_load_t  load;
  b2sp_cmd_t   cmd;
  logic        cdone;
  logic [31:0] h_out [8];

  b2sp_compress u_comp (
    .clk   (clk),
    .rst   (rst),
    .load  (load),
    .cmd   (cmd),
    .done  (cdone),
    .h_out (h_out)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = root_h[out_k];
  assign m_axis_tuser  = out_k;
  assign m_axis_tlast  = (out_k == 3'd7);
  assign out_hs        = m_axis_tvalid && m_axis_tready;

  always_comb begin
    n_raw = s_axis_tdata[34:32];
    n_eff = (!s_axis_tlast || n_raw > 3'd4) ? 3'd4 : n_raw;
    case (n_eff)
      3'd0:    data_m = 32'd0;
      3'd1:    data_m = {24'd0, s_axis_tdata[7:0]};
      3'd2:    data_m = {16'd0, s_axis_tdata[15:0]};
      3'd3:    data_m = {8'd0, s_axis_tdata[23:0]};
      default: data_m = s_axis_tdata[31:0];
    endcase
    cur_leaf = pos[8:6];
    cur_off  = pos[5:2];
    p1       = pos - 9'd1;
    fidx     = p1[8:6];
    loff     = p1[5:2];
    flen     = {1'b0, p1[5:0]} + 7'd1;
  end

  always_comb begin
    if (!holds[job_idx]) begin
      len = 7'd0;
    end else if (job_idx == fidx) begin
      len = flen;
    end else begin
      len = 7'd64;
    end
    if (job_final) begin
      tot_new = tot[job_idx] + COUNTER_BITS'(len);
    end else begin
      tot_new = tot[job_idx] + COUNTER_BITS'(64);
    end
    root_count = {3'(job_idx[1:0]) + 3'd1, 6'd0};
    cmd.start  = (state == S_GO);
    cmd.count  = job_root ? 64'(root_count) : 64'(tot_new);
    cmd.f0     = job_root ? (job_idx == 3'd3) : job_final;
    cmd.f1     = job_root ? (job_idx == 3'd3) : (job_final && job_idx == 3'd7);
  end

  always_comb begin
    blk_raddr   = {job_idx, lc[3:0]};
    chain_raddr = lc[4] ? {job_idx, lc[2:0]} : {job_idx[1:0], lc[3:0]};
    if (!lc[4]) begin
      issue_src = job_root ? SRC_CHAIN : SRC_BLK;
    end else begin
      issue_src = job_root ? SRC_ROOT : SRC_CHAIN;
    end
    if (!lc[4] && !job_root && job_final) begin
      issue_keep = holds[job_idx] && (job_idx != fidx || lc[3:0] <= loff);
    end else begin
      issue_keep = 1'b1;
    end
    case (rd_src)
      SRC_BLK:   rd_sel = blk_q;
      SRC_CHAIN: rd_sel = rd_fresh ? init_word(rd_addr[5:3], rd_addr[2:0], 1'b0) : chain_q;
      default:   rd_sel = rd_rootw;
    endcase
    load.valid = rd_valid;
    load.idx   = rd_idx;
    load.data  = rd_keep ? rd_sel : 32'd0;
  end

  always_ff @(posedge clk) begin
    blk_q   <= blk_mem[blk_raddr];
    chain_q <= chain_mem[chain_raddr];
    if (state == S_PUT) begin
      blk_mem[{cur_leaf, cur_off}] <= in_data;
    end
    if (state == S_STORE) begin
      chain_mem[{job_idx, sc}] <= h_out[sc];
    end
    rd_idx   <= lc;
    rd_src   <= issue_src;
    rd_keep  <= issue_keep;
    rd_addr  <= chain_raddr;
    rd_fresh <= fresh[chain_raddr[5:3]];
    rd_rootw <= root_h[lc[2:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_valid  <= 1'b0;
      lc        <= '0;
      sc        <= '0;
      job_root  <= 1'b0;
      job_final <= 1'b0;
      job_idx   <= '0;
      pos       <= '0;
      holds     <= '0;
      fresh     <= '1;
      out_k     <= '0;
      for (int i = 0; i < 8; i++) begin
        tot[i]    <= '0;
        root_h[i] <= init_word(3'd0, 3'(i), 1'b1);
      end
    end else begin
      rd_valid <= (state == S_LOAD) && (lc < 5'd24);
      case (state)
        S_IDLE: begin
          if (accept) begin
            in_data   <= data_m;
            in_n      <= n_eff;
            in_last   <= s_axis_tlast;
            lc        <= '0;
            job_root  <= 1'b0;
            if (n_eff != 3'd0 && cur_off == 4'd0 && holds[cur_leaf]) begin
              job_final <= 1'b0;
              job_idx   <= cur_leaf;
              state     <= S_LOAD;
            end else if (n_eff != 3'd0) begin
              state <= S_PUT;
            end else begin
              job_final <= 1'b1;
              job_idx   <= '0;
              state     <= S_LOAD;
            end
          end
        end
        S_LOAD: begin
          lc <= lc + 5'd1;
          if (lc == 5'd24) begin
            state <= S_GO;
          end
        end
        S_GO: begin
          if (!job_root) begin
            tot[job_idx] <= tot_new;
          end
          state <= S_RUN;
        end
        S_RUN: begin
          if (cdone) begin
            sc <= '0;
            lc <= '0;
            if (!job_root) begin
              state <= S_STORE;
            end else begin
              for (int i = 0; i < 8; i++) begin
                root_h[i] <= h_out[i];
              end
              if (job_idx == 3'd3) begin
                out_k <= '0;
                state <= S_OUT;
              end else begin
                job_idx <= job_idx + 3'd1;
                state   <= S_LOAD;
              end
            end
          end
        end
        S_STORE: begin
          fresh[job_idx] <= 1'b0;
          sc <= sc + 3'd1;
          if (sc == 3'd7) begin
            if (!job_final) begin
              state <= S_PUT;
            end else if (job_idx == 3'd7) begin
              job_root <= 1'b1;
              job_idx  <= '0;
              state    <= S_LOAD;
            end else begin
              job_idx <= job_idx + 3'd1;
              state   <= S_LOAD;
            end
          end
        end
        S_PUT: begin
          holds[cur_leaf] <= 1'b1;
          pos <= pos + 9'(in_n);
          if (in_last) begin
            job_final <= 1'b1;
            job_root  <= 1'b0;
            job_idx   <= '0;
            lc        <= '0;
            state     <= S_LOAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_OUT: begin
          if (out_hs) begin
            out_k <= out_k + 3'd1;
            if (out_k == 3'd7) begin
              pos       <= '0;
              holds     <= '0;
              fresh     <= '1;
              job_root  <= 1'b0;
              job_final <= 1'b0;
              for (int i = 0; i < 8; i++) begin
                tot[i]    <= '0;
                root_h[i] <= init_word(3'd0, 3'(i), 1'b1);
              end
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: design/b2sp_compress.sv
// BLAKE2s compression unit: four G functions per half round.
// Message and chaining words are loaded one per cycle; depends on b2sp_pkg.
`default_nettype none
module b2sp_compress (
  input  logic                 clk,
  input  logic                 rst,
  input  b2sp_pkg::b2sp_load_t load,
  input  b2sp_pkg::b2sp_cmd_t  cmd,
  output logic                 done,
  output logic [31:0]          h_out [8]
);
  import b2sp_pkg::*;

  logic [31:0] m [16];
  logic [31:0] h [8];
  logic [31:0] v [16];
  logic [31:0] v_next [16];
  logic [3:0]  rnd;
  logic        half;
  logic        running;
  g_t          gr [4];

  always_comb begin
    int ib, ic, id;
    v_next = v;
    for (int i = 0; i < 4; i++) begin
      if (!half) begin
        ib = 4 + i;
        ic = 8 + i;
        id = 12 + i;
        gr[i] = g_mix(v[i], v[ib], v[ic], v[id], m[SIGMA[rnd][8*i +: 4]],
                      m[SIGMA[rnd][8*i+4 +: 4]]);
      end else begin
        ib = 4 + ((i + 1) % 4);
        ic = 8 + ((i + 2) % 4);
        id = 12 + ((i + 3) % 4);
        gr[i] = g_mix(v[i], v[ib], v[ic], v[id], m[SIGMA[rnd][32+8*i +: 4]],
                      m[SIGMA[rnd][36+8*i +: 4]]);
      end
      v_next[i]  = gr[i].a;
      v_next[ib] = gr[i].b;
      v_next[ic] = gr[i].c;
      v_next[id] = gr[i].d;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      h_out[i] = h[i] ^ v[i] ^ v[i+8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      rnd     <= '0;
      half    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        running <= 1'b1;
        rnd     <= '0;
        half    <= 1'b0;
      end else if (running) begin
        half <= ~half;
        if (half) begin
          if (rnd == 4'(LAST_ROUND)) begin
            running <= 1'b0;
            done    <= 1'b1;
          end else begin
            rnd <= rnd + 4'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load.valid) begin
      if (load.idx[4]) begin
        h[load.idx[2:0]] <= load.data;
      end else begin
        m[load.idx[3:0]] <= load.data;
      end
    end
    if (cmd.start) begin
      for (int i = 0; i < 8; i++) begin
        v[i]   <= h[i];
        v[i+8] <= IV[i];
      end
      v[12] <= IV[4] ^ cmd.count[31:0];
      v[13] <= IV[5] ^ cmd.count[63:32];
      v[14] <= IV[6] ^ (cmd.f0 ? ALL_ONES : 32'd0);
      v[15] <= IV[7] ^ (cmd.f1 ? ALL_ONES : 32'd0);
    end else if (running) begin
      v <= v_next;
    end
  end

endmodule
`default_nettype wire

// File: design/b2sp_checker.sv
// Port-level checker for blake2sp_tree_hash_core, attached by the bind statement below.
// Depends only on the top level's ports.
`default_nettype none
module b2sp_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_axis_tvalid,
  input wire        s_axis_tready,
  input wire [39:0] s_axis_tdata,
  input wire        s_axis_tlast,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [31:0] m_axis_tdata,
  input wire [2:0]  m_axis_tuser,
  input wire        m_axis_tlast
);

  // The core never takes a word while digest words are pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(m_axis_tvalid && s_axis_tready))
    else $error("input ready while digest output active");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled digest word changed");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && m_axis_tuser == $past(m_axis_tuser) + 3'd1)
    else $error("digest word index did not advance");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd7)))
    else $error("tlast does not match word index");

  a_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid && s_axis_tready)
    else $error("core not idle after the last digest word");

endmodule

bind blake2sp_tree_hash_core b2sp_checker u_b2sp_checker (.*);
`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for blake2sp_tree_hash_core: streams messages word by word and
// compares every digest word against a BLAKE2sp predictor kept inside this file.
// Depends only on the core; it does not use the package b2sp_pkg.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;

  localparam logic [31:0] CHAIN_IV [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};

  localparam int unsigned MSG_ORDER [10][16] = '{
    '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15},
    '{14, 10, 4, 8, 9, 15, 13, 6, 1, 12, 0, 2, 11, 7, 5, 3},
    '{11, 8, 12, 0, 5, 2, 15, 13, 10, 14, 3, 6, 7, 1, 9, 4},
    '{7, 9, 3, 1, 13, 12, 11, 14, 2, 6, 5, 10, 4, 0, 15, 8},
    '{9, 0, 5, 7, 2, 4, 10, 15, 14, 1, 11, 12, 6, 8, 3, 13},
    '{2, 12, 6, 10, 0, 11, 8, 3, 4, 13, 7, 5, 15, 14, 1, 9},
    '{12, 5, 1, 15, 14, 13, 4, 10, 0, 7, 6, 3, 9, 2, 8, 11},
    '{13, 11, 7, 14, 12, 1, 3, 9, 5, 0, 15, 4, 8, 6, 2, 10},
    '{6, 15, 14, 9, 11, 3, 0, 8, 12, 2, 13, 7, 1, 4, 10, 5},
    '{10, 2, 8, 4, 7, 6, 1, 5, 15, 11, 9, 14, 3, 12, 13, 0}};

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        final_word;
  } digest_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  digest_word_t digest_queue[$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          items_sent = 0;
  bit          tx_jitter = 1'b0;
  bit          rx_jitter = 1'b0;
  int          stall_left = 0;

  logic [255:0] leaf_state [8];
  logic [63:0]  leaf_bytes [8];
  logic [511:0] leaf_block [8];
  logic [7:0]   leaf_busy;
  logic [63:0]  byte_pos;

  blake2sp_tree_hash_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk = ~clk;

  function automatic logic [31:0] rotr(input logic [31:0] w, input int n);
    return (w >> n) | (w << (32 - n));
  endfunction

  function automatic logic [255:0] chain_start(input logic [31:0] offset,
                                               input logic [31:0] depth);
    logic [255:0] h;
    for (int i = 0; i < 8; i++) h[32*i +: 32] = CHAIN_IV[i];
    h[31:0]   ^= 32'h02080020;
    h[95:64]  ^= offset;
    h[127:96] ^= (depth << 16) | 32'h20000000;
    return h;
  endfunction

  function automatic logic [255:0] blake_compress(input logic [255:0] h,
      input logic [511:0] m, input logic [63:0] total, input bit fin_block,
      input bit fin_node);
    logic [31:0] v [16];
    logic [31:0] mw [16];
    int a, b, c, d;
    logic [255:0] r;
    for (int i = 0; i < 16; i++) mw[i] = m[32*i +: 32];
    for (int i = 0; i < 8; i++) begin
      v[i] = h[32*i +: 32];
      v[i+8] = CHAIN_IV[i];
    end
    v[12] ^= total[31:0];
    v[13] ^= total[63:32];
    if (fin_block) v[14] = ~v[14];
    if (fin_node) v[15] = ~v[15];
    for (int rnd = 0; rnd < 10; rnd++) begin
      for (int g = 0; g < 8; g++) begin
        if (g < 4) begin
          a = g; b = g + 4; c = g + 8; d = g + 12;
        end else begin
          a = g - 4; b = 4 + (g - 3) % 4; c = 8 + (g - 2) % 4; d = 12 + (g - 1) % 4;
        end
        v[a] = v[a] + v[b] + mw[MSG_ORDER[rnd][2*g]];
        v[d] = rotr(v[d] ^ v[a], 16);
        v[c] = v[c] + v[d];
        v[b] = rotr(v[b] ^ v[c], 12);
        v[a] = v[a] + v[b] + mw[MSG_ORDER[rnd][2*g+1]];
        v[d] = rotr(v[d] ^ v[a], 8);
        v[c] = v[c] + v[d];
        v[b] = rotr(v[b] ^ v[c], 7);
      end
    end
    for (int i = 0; i < 8; i++) r[32*i +: 32] = h[32*i +: 32] ^ v[i] ^ v[i+8];
    return r;
  endfunction

  task automatic tree_clear();
    for (int i = 0; i < 8; i++) begin
      leaf_state[i] = chain_start(32'(i), 32'd0);
      leaf_bytes[i] = '0;
      leaf_block[i] = '0;
    end
    leaf_busy = '0;
    byte_pos = '0;
  endtask

  task automatic tree_absorb(input logic [31:0] data, input logic [2:0] count,
                             input logic lst);
    int n;
    logic [2:0] leaf;
    logic [3:0] off;
    logic [63:0] tail;
    logic [63:0] len;
    logic [255:0] root;
    digest_word_t dw;
    n = (!lst || count > 4) ? 4 : int'(count);
    if (n < 4) data &= (32'h1 << (8 * n)) - 32'h1;
    if (n > 0) begin
      leaf = byte_pos[8:6];
      off = byte_pos[5:2];
      if (off == 0) begin
        if (leaf_busy[leaf]) begin
          leaf_bytes[leaf] += 64'd64;
          leaf_state[leaf] = blake_compress(leaf_state[leaf], leaf_block[leaf],
                                            leaf_bytes[leaf], 1'b0, 1'b0);
        end
        leaf_block[leaf] = '0;
      end
      leaf_block[leaf][32*off +: 32] = data;
      leaf_busy[leaf] = 1'b1;
      byte_pos += 64'(n);
    end
    if (lst) begin
      tail = byte_pos - 64'd1;
      for (int i = 0; i < 8; i++) begin
        len = 64'd0;
        if (leaf_busy[i]) len = (3'(i) == tail[8:6]) ? {58'd0, tail[5:0]} + 64'd1 : 64'd64;
        else leaf_block[i] = '0;
        leaf_bytes[i] += len;
        leaf_state[i] = blake_compress(leaf_state[i], leaf_block[i], leaf_bytes[i],
                                       1'b1, i == 7);
      end
      root = chain_start(32'd0, 32'd1);
      for (int j = 0; j < 4; j++)
        root = blake_compress(root, {leaf_state[2*j+1], leaf_state[2*j]},
                              64'(64 * (j + 1)), j == 3, j == 3);
      for (int k = 0; k < 8; k++) begin
        dw.word = root[32*k +: 32];
        dw.index = 3'(k);
        dw.final_word = (k == 7);
        digest_queue.push_back(dw);
      end
      tree_clear();
    end
  endtask

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_word(input logic [31:0] data, input logic [2:0] count,
                           input logic lst);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, count, data};
    s_axis_tlast  <= lst;
    do @(posedge clk); while (!s_axis_tready);
    tree_absorb(data, count, lst);
    items_sent++;
    gap = tx_jitter ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_message(input int words, input logic [2:0] tail_count);
    for (int i = 0; i < words - 1; i++) send_word($urandom, 3'd4, 1'b0);
    send_word($urandom, tail_count, 1'b1);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (digest_queue.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_message();
    send_word(32'hFFFFFFFF, 3'd0, 1'b1);
    send_word(32'h00000000, 3'd0, 1'b1);
  endtask

  task automatic test_partial_final_word();
    for (int c = 1; c <= 4; c++) send_word(32'hFFFFFFFF, 3'(c), 1'b1);
    send_word(32'h00000000, 3'd4, 1'b1);
  endtask

  task automatic test_count_ignored();
    send_word(32'hA5A5A5A5, 3'd0, 1'b0);
    send_word(32'h5A5A5A5A, 3'd2, 1'b0);
    send_word(32'h12345678, 3'd7, 1'b0);
    send_word(32'h87654321, 3'd5, 1'b1);
    send_word(32'hDEADBEEF, 3'd6, 1'b1);
    send_word(32'hCAFEF00D, 3'd3, 1'b0);
    send_word(32'h0BADF00D, 3'd0, 1'b1);
  endtask

  task automatic test_block_edges();
    send_message(16, 3'd4);
    send_message(17, 3'd1);
  endtask

  task automatic test_random_messages();
    int words;
    tx_jitter = 1'b1;
    rx_jitter = 1'b1;
    send_message(40, 3'd3);
    while (items_sent < 120) begin
      if ($urandom_range(0, 7) == 0) words = $urandom_range(20, 40);
      else words = $urandom_range(1, 10);
      send_message(words, 3'($urandom_range(0, 7)));
      if ($urandom_range(0, 3) == 0) drain();
    end
  endtask

  task automatic test_sender_pause();
    tx_jitter = 1'b0;
    send_message(5, 3'd2);
    drain();
    send_message(3, 3'd4);
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (rx_jitter && $urandom_range(0, 5) == 0)
        stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                  : $urandom_range(10, 40);
    end
  end

  always @(posedge clk) begin
    digest_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (digest_queue.size() == 0) begin
        $display("%0t: digest word %h with nothing expected", $time, m_axis_tdata);
        error_count++;
      end else begin
        want = digest_queue.pop_front();
        if (m_axis_tdata !== want.word) begin
          $display("%0t: digest word expected %h actual %h", $time, want.word, m_axis_tdata);
          error_count++;
        end
        if (m_axis_tuser !== want.index) begin
          $display("%0t: word index expected %0d actual %0d", $time, want.index,
                   m_axis_tuser);
          error_count++;
        end
        if (m_axis_tlast !== want.final_word) begin
          $display("%0t: last flag expected %b actual %b", $time, want.final_word,
                   m_axis_tlast);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("blake2sp_tree_hash_core test failed");
      $finish;
    end
  end

  initial begin
    tree_clear();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_message();
    test_partial_final_word();
    test_count_ignored();
    test_block_edges();
    test_sender_pause();
    test_random_messages();
    drain();
    repeat (50) @(posedge clk);
    if (error_count == 0 && digest_queue.size() == 0) begin
      $display("blake2sp_tree_hash_core test passed");
    end else begin
      $display("blake2sp_tree_hash_core test failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
design/b2sp_pkg.sv
design/b2sp_compress.sv
design/blake2sp_tree_hash_core.sv
design/b2sp_checker.sv
dv/tb_top.sv
